// File: design/lsfd_pkg.sv
// Package for the LSB steganography frame decoder.
// Holds the parser phase, result kind and config index codes, the result struct, clamp_len and magic_mask.
// No dependencies.
package lsfd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_MAGIC    = 3'd1,
        PH_EXT_LEN  = 3'd2,
        PH_EXT_CHAR = 3'd3,
        PH_PAY_LEN  = 3'd4,
        PH_PAYLOAD  = 3'd5,
        PH_IDLE     = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        KIND_MAGIC_OK  = 3'd0,
        KIND_MAGIC_BAD = 3'd1,
        KIND_EXT_LEN   = 3'd2,
        KIND_EXT_CHAR  = 3'd3,
        KIND_PAY_LEN   = 3'd4,
        KIND_PAY_BYTE  = 3'd5
    } t_kind;

    typedef enum logic [0:0] {
        CFG_MAGIC_KEY = 1'b0,
        CFG_MAGIC_LEN = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic        last;
    } t_result;

    localparam logic [3:0] MagicLenReset = 4'd2;
    localparam logic [6:0] LenBits       = 7'd32;
    localparam logic [6:0] ByteBits      = 7'd8;

    // clamp magic length to 1..8 characters
    function automatic logic [3:0] clamp_len(input logic [3:0] len);
        logic [3:0] res;
        res = len;
        if (len == 4'd0) begin
            res = 4'd1;
        end else if (len > 4'd8) begin
            res = 4'd8;
        end
        return res;
    endfunction

    // low len bytes set
    function automatic logic [63:0] magic_mask(input logic [3:0] len);
        logic [63:0] mask;
        for (int b = 0; b < 8; b++) begin
            mask[b*8 +: 8] = (4'(b) < len) ? 8'hFF : 8'h00;
        end
        return mask;
    endfunction

endpackage

// File: design/lsfd_parser.sv
// Frame parser of the LSB steganography frame decoder: header skip, bit packing, field parse.
// Produces at most one result per accepted transaction, combinationally from its state and inputs.
// Depends on lsfd_pkg.
module lsfd_parser #(
    parameter int HEADER_BYTES = 54
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_cmd,
    input  logic             i_bit,
    input  logic [63:0]      i_magic_key,
    input  logic [3:0]       i_magic_len,
    output logic             o_res_valid,
    output lsfd_pkg::t_result o_res
);

    localparam logic [5:0] HdrLen = 6'(HEADER_BYTES);
    localparam lsfd_pkg::t_phase StartPhase =
        (HEADER_BYTES == 0) ? lsfd_pkg::PH_MAGIC : lsfd_pkg::PH_HEADER;

    lsfd_pkg::t_phase r_phase, n_phase;
    logic [63:0]      r_shift, n_shift;
    logic [6:0]       r_count, n_count;
    logic [31:0]      r_items, n_items;
    logic [5:0]       r_hcnt,  n_hcnt;

    logic [63:0] shift_nx;
    logic [6:0]  count_nx;
    logic [6:0]  need;
    logic [3:0]  len_c;
    logic [63:0] mask;
    logic [31:0] val;
    logic [31:0] items_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= StartPhase;
            r_shift <= '0;
            r_count <= '0;
            r_items <= '0;
            r_hcnt  <= '0;
        end else begin
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_count <= n_count;
            r_items <= n_items;
            r_hcnt  <= n_hcnt;
        end
    end

    assign shift_nx  = {r_shift[62:0], i_bit};
    assign count_nx  = r_count + 7'd1;
    assign len_c     = lsfd_pkg::clamp_len(i_magic_len);
    assign mask      = lsfd_pkg::magic_mask(len_c);
    assign val       = shift_nx[31:0];
    assign items_dec = r_items - 32'd1;

    always_comb begin
        case (r_phase)
            lsfd_pkg::PH_MAGIC:   need = {len_c, 3'b000};
            lsfd_pkg::PH_EXT_LEN,
            lsfd_pkg::PH_PAY_LEN: need = lsfd_pkg::LenBits;
            default:              need = lsfd_pkg::ByteBits;
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_shift     = r_shift;
        n_count     = r_count;
        n_items     = r_items;
        n_hcnt      = r_hcnt;
        o_res_valid = 1'b0;
        o_res.kind  = lsfd_pkg::KIND_PAY_BYTE;
        o_res.value = {24'd0, val[7:0]};
        o_res.last  = 1'b0;
        if (i_accept) begin
            if (i_cmd) begin
                n_phase = StartPhase;
                n_shift = '0;
                n_count = '0;
                n_items = '0;
                n_hcnt  = '0;
            end else if (r_phase == lsfd_pkg::PH_HEADER) begin
                n_hcnt = r_hcnt + 6'd1;
                if (n_hcnt >= HdrLen) begin
                    n_phase = lsfd_pkg::PH_MAGIC;
                end
            end else if (r_phase != lsfd_pkg::PH_IDLE) begin
                n_shift = shift_nx;
                n_count = count_nx;
                if (count_nx >= need) begin
                    o_res_valid = 1'b1;
                    n_shift     = '0;
                    n_count     = '0;
                    case (r_phase)
                        lsfd_pkg::PH_MAGIC: begin
                            o_res.value = '0;
                            if ((shift_nx & mask) == (i_magic_key & mask)) begin
                                o_res.kind = lsfd_pkg::KIND_MAGIC_OK;
                                n_phase    = lsfd_pkg::PH_EXT_LEN;
                            end else begin
                                o_res.kind = lsfd_pkg::KIND_MAGIC_BAD;
                                n_phase    = lsfd_pkg::PH_IDLE;
                            end
                        end
                        lsfd_pkg::PH_EXT_LEN: begin
                            o_res.kind  = lsfd_pkg::KIND_EXT_LEN;
                            o_res.value = val;
                            n_items     = val;
                            n_phase     = (val != 32'd0) ? lsfd_pkg::PH_EXT_CHAR
                                                         : lsfd_pkg::PH_PAY_LEN;
                        end
                        lsfd_pkg::PH_EXT_CHAR: begin
                            o_res.kind = lsfd_pkg::KIND_EXT_CHAR;
                            n_items    = items_dec;
                            if (items_dec == 32'd0) begin
                                n_phase = lsfd_pkg::PH_PAY_LEN;
                            end
                        end
                        lsfd_pkg::PH_PAY_LEN: begin
                            o_res.kind  = lsfd_pkg::KIND_PAY_LEN;
                            o_res.value = val;
                            n_items     = val;
                            n_phase     = (val != 32'd0) ? lsfd_pkg::PH_PAYLOAD
                                                         : lsfd_pkg::PH_IDLE;
                        end
                        default: begin
                            o_res.kind = lsfd_pkg::KIND_PAY_BYTE;
                            o_res.last = (r_items == 32'd1);
                            n_items    = items_dec;
                            if (items_dec == 32'd0) begin
                                n_phase = lsfd_pkg::PH_IDLE;
                            end
                        end
                    endcase
                end
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 7'd64)
        else $error("bit count exceeds 64");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_cmd) |=> (r_phase == StartPhase && r_count == 7'd0 && r_hcnt == 6'd0))
        else $error("restart did not clear parser state");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> (r_phase == lsfd_pkg::PH_IDLE))
        else $error("last payload byte did not end the frame");

    a_header_no_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lsfd_pkg::PH_HEADER) |-> (r_count == 7'd0 && r_shift == 64'd0))
        else $error("bits collected during header skip");

endmodule

// File: design/lsb_stego_frame_decoder_unit.sv
// LSB steganography frame decoder, top level: ports, config registers and output buffer.
// Each result is registered in the output buffer before it shows on m_axis; one byte per cycle
// sustained while m_axis is not stalled. A two-entry output buffer (register plus skid) keeps
// s_axis_tready registered. Reset (synchronous, i_rst_n low) empties the buffer, returns the parser
// to its start phase, sets magic_key to 0 and magic_length to 2. Depends on lsfd_pkg, lsfd_parser.
module lsb_stego_frame_decoder_unit #(
    parameter int HEADER_BYTES = 54
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_byte
    input  logic        s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] item_value
    output logic [2:0]  m_axis_tuser,   // [2:0] item_kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [63:0]       r_magic_key;
    logic [3:0]        r_magic_len;
    logic              r_out_valid, r_skd_valid;
    lsfd_pkg::t_result r_out, r_skd;

    logic              accept, pop, push;
    logic              res_valid;
    lsfd_pkg::t_result res;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skd_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = r_out_valid && m_axis_tready;
    assign push          = accept && res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_key <= '0;
            r_magic_len <= lsfd_pkg::MagicLenReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lsfd_pkg::CFG_MAGIC_KEY: r_magic_key <= i_cfg_data;
                lsfd_pkg::CFG_MAGIC_LEN: r_magic_len <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    lsfd_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cmd       (s_axis_tuser),
        .i_bit       (s_axis_tdata[0]),
        .i_magic_key (r_magic_key),
        .i_magic_len (r_magic_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (pop) begin
            if (r_skd_valid) begin
                r_skd_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_skd_valid ? r_skd : res;
        end else if (push) begin
            if (!r_out_valid) begin
                r_out <= res;
            end else begin
                r_skd <= res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.value;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skd_valid) |-> $past(r_out_valid && !m_axis_tready))
        else $error("skid filled without an output stall");

    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == lsfd_pkg::KIND_PAY_BYTE))
        else $error("tlast on a result that is not a payload byte");

endmodule
